// File: design/crdc_pkg.sv
// crdc_pkg: shared types and constants
// for chroma_resample_depth_convert; no dependencies
`default_nettype none
package crdc_pkg;
  localparam logic [1:0] LAYOUT_444  = 2'd0;
  localparam logic [1:0] LAYOUT_422  = 2'd1;
  localparam logic [1:0] LAYOUT_420  = 2'd2;
  localparam logic [1:0] LAYOUT_GRAY = 2'd3;

  localparam logic [2:0] REG_SRC_DEPTH = 3'd0;
  localparam logic [2:0] REG_TGT_DEPTH = 3'd1;
  localparam logic [2:0] REG_LAYOUT    = 3'd2;
  localparam logic [2:0] REG_SRC_GRAY  = 3'd3;
  localparam logic [2:0] REG_WIDTH     = 3'd4;
  localparam logic [2:0] REG_HEIGHT    = 3'd5;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic        valid;
    logic        chroma_valid;
    logic        frame_end;
    logic [1:0]  layout;
    logic        odd_col;
    logic        odd_row;
    logic        last_col;
    logic        last_row;
    logic [11:0] col;
    logic [15:0] row;
  } crdc_ctl_t;
endpackage
`default_nettype wire

// File: design/chroma_resample_depth_convert.sv
// chroma_resample_depth_convert: top level, config registers, counters,
// pair sums and pipeline; depends on crdc_pkg, crdc_row_mem, crdc_scale
`default_nettype none
// one pixel item per clock, raster order. luma is rescaled to the target depth;
// chroma is averaged over 2x1 (4:2:2) or 2x2 (4:2:0) blocks and rescaled, with
// odd right and bottom edges counted twice. one result item per input item,
// after a row store read and the three stage rescale pipeline. the pipeline
// advances whenever the output register is free, so an item is taken every
// cycle while the output keeps flowing. the row store holds even-row pair
// sums and needs no clearing after reset.
module chroma_resample_depth_convert #(
  parameter int MAX_WIDTH = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // src_luma, src_cb, src_cr
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [79:0] out_tdata,  // luma_out, cb_out, cr_out, chroma_col, chroma_row
  output logic      [1:0]  out_tuser,  // chroma_valid, frame_end
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import crdc_pkg::*;
  localparam int HALF = (MAX_WIDTH + 1) / 2;
  localparam int AW = (HALF > 1) ? $clog2(HALF) : 1;
  localparam logic [4:0] MAXD = 5'(SAMPLE_BITS);

  logic [4:0]  src_depth_r, tgt_depth_r;
  logic [1:0]  layout_r;
  logic        src_gray_r;
  logic [12:0] width_r;
  logic [15:0] height_r;
  logic        wr;
  logic [2:0]  ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_depth_r <= 5'd8;
      tgt_depth_r <= 5'd8;
      layout_r    <= LAYOUT_420;
      src_gray_r  <= 1'b0;
      width_r     <= 13'd1920;
      height_r    <= 16'd1080;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      case (ridx)
        REG_SRC_DEPTH: src_depth_r <= cfg_pwdata[4:0];
        REG_TGT_DEPTH: tgt_depth_r <= cfg_pwdata[4:0];
        REG_LAYOUT:    layout_r    <= cfg_pwdata[1:0];
        REG_SRC_GRAY:  src_gray_r  <= cfg_pwdata[0];
        REG_WIDTH:     width_r     <= cfg_pwdata[12:0];
        REG_HEIGHT:    height_r    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    cfg_prdata = '0;
    case (ridx)
      REG_SRC_DEPTH: cfg_prdata = 32'(src_depth_r);
      REG_TGT_DEPTH: cfg_prdata = 32'(tgt_depth_r);
      REG_LAYOUT:    cfg_prdata = 32'(layout_r);
      REG_SRC_GRAY:  cfg_prdata = 32'(src_gray_r);
      REG_WIDTH:     cfg_prdata = 32'(width_r);
      REG_HEIGHT:    cfg_prdata = 32'(height_r);
      default:       cfg_prdata = '0;
    endcase
    if (cfg_paddr[1:0] != 2'b00) cfg_prdata = '0;
  end

  // saturated settings
  logic [4:0]  sd, td;
  logic [14:0] w_sat;
  logic [15:0] h_sat;
  assign sd = (src_depth_r < 5'd8) ? 5'd8 : (src_depth_r > MAXD) ? MAXD : src_depth_r;
  assign td = (tgt_depth_r < 5'd8) ? 5'd8 : (tgt_depth_r > MAXD) ? MAXD : tgt_depth_r;
  assign w_sat = (width_r == 13'd0) ? 15'd1 :
                 ({2'b0, width_r} > 15'(MAX_WIDTH)) ? 15'(MAX_WIDTH) : {2'b0, width_r};
  assign h_sat = (height_r == 16'd0) ? 16'd1 : height_r;

  // pipeline advance: stall everything when output is full and not taken
  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  logic acc;
  assign acc = in_tvalid && in_tready;

  // stage 0: counters and horizontal pairs
  logic [11:0] col_r;
  logic [15:0] row_r;
  logic [16:0] pair_cb_r, pair_cr_r;
  logic        last_col, last_row, odd, done;
  logic [15:0] cb, cr, neutral;
  logic [16:0] hcb, hcr;
  assign last_col = {3'b0, col_r} >= w_sat - 15'd1;
  assign last_row = row_r >= h_sat - 16'd1;
  assign neutral = 16'(17'd1 << (sd - 5'd1));
  assign cb = src_gray_r ? neutral : in_tdata[31:16];
  assign cr = src_gray_r ? neutral : in_tdata[47:32];
  assign odd = col_r[0];
  assign done = odd || last_col;
  assign hcb = odd ? pair_cb_r + 17'(cb) : {cb, 1'b0};
  assign hcr = odd ? pair_cr_r + 17'(cr) : {cr, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pair_cb_r <= '0;
      pair_cr_r <= '0;
    end else if (acc) begin
      // left sample of a pair is held only in the subsampled layouts
      if (!odd && (layout_r inside {LAYOUT_422, LAYOUT_420})) begin
        pair_cb_r <= 17'(cb);
        pair_cr_r <= 17'(cr);
      end
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? 16'd0 : row_r + 16'd1;
      end else begin
        col_r <= col_r + 12'd1;
      end
    end
  end

  // row store access
  logic [AW-1:0] idx;
  logic          mem_we;
  logic [33:0]   mem_rd;
  assign idx = AW'(col_r[11:1]);
  assign mem_we = acc && done && layout_r == LAYOUT_420 && !row_r[0];
  crdc_row_mem #(.DEPTH(HALF), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(idx), .wdata({hcb, hcr}),
    .re(en), .raddr(idx), .rdata(mem_rd)
  );

  // stage 1 registers
  crdc_ctl_t   c1_r, c2_r, c3_r, c4_r;
  crdc_ctl_t   c0;
  logic [15:0] luma1_r;
  logic [16:0] hcb1_r, hcr1_r;
  logic [15:0] cb1_r, cr1_r;
  always_comb begin
    c0 = '0;
    c0.valid = acc;
    c0.layout = layout_r;
    c0.odd_col = odd;
    c0.odd_row = row_r[0];
    c0.last_col = last_col;
    c0.last_row = last_row;
    c0.frame_end = last_col && last_row;
    c0.col = col_r;
    c0.row = row_r;
    case (layout_r)
      LAYOUT_444: c0.chroma_valid = 1'b1;
      LAYOUT_422: c0.chroma_valid = done;
      LAYOUT_420: c0.chroma_valid = done && (row_r[0] || last_row);
      default:    c0.chroma_valid = 1'b0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) c1_r <= '0;
    else if (en) c1_r <= c0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      luma1_r <= in_tdata[15:0];
      hcb1_r <= hcb;
      hcr1_r <= hcr;
      cb1_r <= cb;
      cr1_r <= cr;
    end
  end

  // average select with row store data
  logic [16:0] avg_cb, avg_cr;
  logic [17:0] s4cb, s4cr;
  always_comb begin
    s4cb = c1_r.odd_row ? 18'(mem_rd[33:17]) + 18'(hcb1_r) + 18'd2
                        : {hcb1_r, 1'b0} + 18'd2;
    s4cr = c1_r.odd_row ? 18'(mem_rd[16:0]) + 18'(hcr1_r) + 18'd2
                        : {hcr1_r, 1'b0} + 18'd2;
    case (c1_r.layout)
      LAYOUT_422: begin
        avg_cb = 17'((18'(hcb1_r) + 18'd1) >> 1);
        avg_cr = 17'((18'(hcr1_r) + 18'd1) >> 1);
      end
      LAYOUT_420: begin
        avg_cb = 17'(s4cb >> 2);
        avg_cr = 17'(s4cr >> 2);
      end
      default: begin
        avg_cb = 17'(cb1_r);
        avg_cr = 17'(cr1_r);
      end
    endcase
  end

  logic [15:0] yq, cbq, crq;
  crdc_scale u_sy (.clk(clk), .en(en), .v_in({1'b0, luma1_r}), .sd(sd), .td(td), .q_out(yq));
  crdc_scale u_sb (.clk(clk), .en(en), .v_in(avg_cb), .sd(sd), .td(td), .q_out(cbq));
  crdc_scale u_sr (.clk(clk), .en(en), .v_in(avg_cr), .sd(sd), .td(td), .q_out(crq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
    end else if (en) begin
      c2_r <= c1_r;
      c3_r <= c2_r;
      c4_r <= c3_r;
    end
  end

  logic [11:0] ocol;
  logic [15:0] orow;
  assign out_tvalid = c4_r.valid;
  assign ocol = !c4_r.chroma_valid ? 12'd0 :
                (c4_r.layout == LAYOUT_444) ? c4_r.col : {1'b0, c4_r.col[11:1]};
  assign orow = !c4_r.chroma_valid ? 16'd0 :
                (c4_r.layout == LAYOUT_420) ? {1'b0, c4_r.row[15:1]} : c4_r.row;
  assign out_tdata = {4'd0, orow, ocol,
                      c4_r.chroma_valid ? crq : 16'd0,
                      c4_r.chroma_valid ? cbq : 16'd0, yq};
  assign out_tuser = {c4_r.frame_end, c4_r.chroma_valid};
endmodule
`default_nettype wire

// File: design/crdc_scale.sv
// crdc_scale: pipelined depth rescale (v*tmax + smax/2) / smax, three stages
// depends on crdc_pkg; division by smax = 2^sd-1 done by a reciprocal series
`default_nettype none
module crdc_scale (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [16:0] v_in,
  input  wire logic [4:0]  sd,
  input  wire logic [4:0]  td,
  output logic      [15:0] q_out
);
  import crdc_pkg::*;
  logic [15:0] smax, tmax, v_sat;
  logic [31:0] prod_r;
  logic [4:0]  sd1_r, sd2_r;
  logic [15:0] smax1_r;
  logic [32:0] num_r;
  logic [32:0] num_c;
  logic [32:0] q_c;
  logic [32:0] rem_c;
  logic [15:0] q_nxt;
  assign smax = 16'((17'd1 << sd) - 17'd1);
  assign tmax = 16'((17'd1 << td) - 17'd1);
  assign v_sat = (v_in > {1'b0, smax}) ? smax : v_in[15:0];
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= v_sat * tmax;
      sd1_r   <= sd;
      smax1_r <= smax;
    end
  end
  assign num_c = {1'b0, prod_r} + {18'd0, smax1_r[15:1]};
  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_c;
      sd2_r <= sd1_r;
    end
  end
  // n/(2^k-1): q ~ n>>k + n>>2k + n>>3k, short by at most three,
  // then correct by comparing the remainder against 1x, 2x and 3x the divisor
  always_comb begin
    logic [32:0] sm, sm2, sm3;
    sm    = 33'((34'd1 << sd2_r) - 34'd1);
    sm2   = sm << 1;
    sm3   = sm2 + sm;
    q_c   = (num_r >> sd2_r) + (num_r >> (6'(sd2_r) << 1)) + (num_r >> (6'(sd2_r) * 6'd3));
    rem_c = num_r - ((q_c << sd2_r) - q_c);
    if (rem_c >= sm3) q_c = q_c + 33'd3;
    else if (rem_c >= sm2) q_c = q_c + 33'd2;
    else if (rem_c >= sm) q_c = q_c + 33'd1;
    q_nxt = q_c[15:0];
  end
  always_ff @(posedge clk) begin
    if (en) q_out <= q_nxt;
  end
endmodule
`default_nettype wire

// File: design/crdc_row_mem.sv
// crdc_row_mem: row store of horizontal chroma pair sums, one read port and
// one write port, registered read; depends on crdc_pkg
`default_nettype none
module crdc_row_mem #(
  parameter int DEPTH = 2048,
  parameter int AW = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [33:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [33:0]   rdata
);
  import crdc_pkg::*;
  logic [33:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
